### hw/rtl/mbrs_pkg.sv
// shared types, constants and helpers for the modbus rtu slave register file
// no dependencies
package mbrs_pkg;

  // sizes
  localparam int RegCount       = 224;
  localparam int ControlRegs    = 32;
  localparam int UpperWriteRegs = 96;
  localparam int FrameMax       = 256;
  localparam int RegAddrW       = $clog2(RegCount);
  localparam int FrameAddrW     = $clog2(FrameMax);
  localparam int FrameLenW      = $clog2(FrameMax + 1);
  localparam int QueueDepth     = 4;
  localparam int QueuePtrW      = $clog2(QueueDepth);
  localparam int QueueCntW      = $clog2(QueueDepth + 1);
  localparam int CfgIdxW        = 2;

  // input op codes
  localparam logic [2:0] OpByte  = 3'd0;
  localparam logic [2:0] OpTick  = 3'd1;
  localparam logic [2:0] OpTxRdy = 3'd2;
  localparam logic [2:0] OpLRead = 3'd3;
  localparam logic [2:0] OpLWrite = 3'd4;

  // result kinds
  localparam logic [2:0] KindNone = 3'd0;
  localparam logic [2:0] KindTx   = 3'd1;
  localparam logic [2:0] KindSave = 3'd2;
  localparam logic [2:0] KindRead = 3'd3;
  localparam logic [2:0] KindDrop = 3'd4;

  // drop reasons
  localparam logic [1:0] DropShort    = 2'd0;
  localparam logic [1:0] DropAddr     = 2'd1;
  localparam logic [1:0] DropCrc      = 2'd2;
  localparam logic [1:0] DropOverflow = 2'd3;

  // reply kinds
  localparam logic [1:0] RplNone  = 2'd0;
  localparam logic [1:0] RplRead  = 2'd1;
  localparam logic [1:0] RplWrite = 2'd2;
  localparam logic [1:0] RplExc   = 2'd3;

  // modbus function and exception codes
  localparam logic [7:0] FuncRead   = 8'h03;
  localparam logic [7:0] FuncWrite1 = 8'h06;
  localparam logic [7:0] FuncWriteN = 8'h10;
  localparam logic [7:0] ExcFlag    = 8'h80;
  localparam logic [7:0] ExcFunc    = 8'h01;
  localparam logic [7:0] ExcAddr    = 8'h02;
  localparam logic [7:0] ExcValue   = 8'h03;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSlave   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSilence = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSaveLim = 2'd2;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [2:0] {
    CMD_BYTE,
    CMD_TICK,
    CMD_TX,
    CMD_LRD,
    CMD_LWR
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  rx_byte;
    logic [7:0]  index;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] silence_ticks;
    logic [7:0]  save_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [7:0]  save_index;
    logic [15:0] save_value;
    logic [15:0] read_value;
    logic [1:0]  drop_reason;
  } res_t;

  // crc-16 modbus, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic res_t mk_tx(input logic [7:0] b, input logic last);
    res_t r;
    r = '0;
    r.kind = KindTx;
    r.tx_byte = b;
    r.tx_last = last;
    return r;
  endfunction

  function automatic res_t mk_drop(input logic [1:0] why);
    res_t r;
    r = '0;
    r.kind = KindDrop;
    r.drop_reason = why;
    return r;
  endfunction

endpackage

### hw/rtl/mbrs_ram.sv
// generic single write port ram with registered read
// no dependencies
module mbrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/mbrs_front.sv
// front end: accepts input words, classifies the op and queues commands
// depends on mbrs_pkg
module mbrs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           op_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           local_index_i,
  input  logic [15:0]          local_value_i,
  output logic                 item_valid_o,
  output mbrs_pkg::item_t      item_o,
  input  logic                 item_pop_i
);

  mbrs_pkg::item_t                 q_mem [mbrs_pkg::QueueDepth];
  logic [mbrs_pkg::QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mbrs_pkg::QueueCntW-1:0]  cnt_q, cnt_d;
  logic                            known;
  logic                            push;
  mbrs_pkg::item_t                 cls;

  // classify the op code
  always_comb begin
    known = 1'b1;
    cls.rx_byte = rx_byte_i;
    cls.index   = local_index_i;
    cls.value   = local_value_i;
    case (op_i)
      mbrs_pkg::OpByte:   cls.cmd = mbrs_pkg::CMD_BYTE;
      mbrs_pkg::OpTick:   cls.cmd = mbrs_pkg::CMD_TICK;
      mbrs_pkg::OpTxRdy:  cls.cmd = mbrs_pkg::CMD_TX;
      mbrs_pkg::OpLRead:  cls.cmd = mbrs_pkg::CMD_LRD;
      mbrs_pkg::OpLWrite: cls.cmd = mbrs_pkg::CMD_LWR;
      default: begin
        cls.cmd = mbrs_pkg::CMD_TICK;
        known = 1'b0;
      end
    endcase
  end

  assign in_stall_o   = (cnt_q == mbrs_pkg::QueueCntW'(mbrs_pkg::QueueDepth));
  assign push         = in_valid_i && !in_stall_o && known;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem[rd_ptr_q];

  // queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !item_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && item_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

### hw/rtl/mbrs_back.sv
// back end: frame store, frame check, register file and reply streaming
// depends on mbrs_pkg and mbrs_ram
module mbrs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mbrs_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  mbrs_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mbrs_pkg::res_t  out_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT,
    ST_LRD,
    ST_TX_RD,
    ST_SWEEP,
    ST_EVAL,
    ST_MW_A,
    ST_MW_B,
    ST_MW_C
  } state_e;

  localparam int RA = mbrs_pkg::RegAddrW;
  localparam int FA = mbrs_pkg::FrameAddrW;
  localparam int FL = mbrs_pkg::FrameLenW;

  state_e state_q, state_d;

  // frame state
  logic          open_q, open_d;
  logic [FL-1:0] len_q, len_d, flen_q, flen_d;
  logic [15:0]   sil_q, sil_d;
  logic [8:0]    cnt_q, cnt_d;
  logic [15:0]   crc_q, crc_d, rxcrc_q, rxcrc_d;
  logic [7:0]    hdr_q [7];
  logic [7:0]    hdr_d [7];

  // reply state
  logic [1:0]    rk_q, rk_d;
  logic [8:0]    rpos_q, rpos_d;
  logic [15:0]   rcrc_q, rcrc_d;
  logic [7:0]    raddr_q, raddr_d, rfunc_q, rfunc_d, rcode_q, rcode_d;
  logic [15:0]   rstart_q, rstart_d, rword_q, rword_d;

  // multiple write loop
  logic [7:0]    mi_q, mi_d, mhi_q, mhi_d;
  logic [8:0]    mp_q, mp_d;

  // results
  mbrs_pkg::res_t res_q, res_d, out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic           ores_free;

  // register file valid bits
  logic           reg_vld_q [mbrs_pkg::RegCount];
  logic           rvld_q, rvld_d;

  // ram ports
  logic          fs_we;
  logic [FA-1:0] fs_waddr, fs_raddr;
  logic [7:0]    fs_wdata, fs_rdata;
  logic          rf_we;
  logic [RA-1:0] rf_waddr, rf_raddr;
  logic [15:0]   rf_wdata, rf_rdata;

  // scratch
  logic [FL-1:0] len_eff;
  logic [15:0]   sil_n;
  logic [9:0]    body_len;
  logic [7:0]    simple_byte, tx_b;
  logic [8:0]    pm3;
  logic [15:0]   rv;
  logic [7:0]    func;
  logic [15:0]   start, n;
  logic [16:0]   end_sum;
  logic [8:0]    widx;
  logic [7:0]    lo_b;

  mbrs_ram #(.Width(8), .Depth(mbrs_pkg::FrameMax)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  mbrs_ram #(.Width(16), .Depth(mbrs_pkg::RegCount)) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  assign ores_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // reply byte helpers
  always_comb begin
    if (rk_q == mbrs_pkg::RplRead) begin
      body_len = 10'd3 + {rword_q[8:0], 1'b0};
    end else if (rk_q == mbrs_pkg::RplWrite) begin
      body_len = 10'd6;
    end else begin
      body_len = 10'd3;
    end
    pm3 = rpos_q - 9'd3;
    simple_byte = 8'h00;
    if (rpos_q == 9'd0) begin
      simple_byte = raddr_q;
    end else if (rk_q == mbrs_pkg::RplExc) begin
      simple_byte = (rpos_q == 9'd1) ? (rfunc_q | mbrs_pkg::ExcFlag) : rcode_q;
    end else if (rk_q == mbrs_pkg::RplRead) begin
      simple_byte = (rpos_q == 9'd1) ? mbrs_pkg::FuncRead : {rword_q[6:0], 1'b0};
    end else begin
      case (rpos_q)
        9'd1:    simple_byte = rfunc_q;
        9'd2:    simple_byte = rstart_q[15:8];
        9'd3:    simple_byte = rstart_q[7:0];
        9'd4:    simple_byte = rword_q[15:8];
        default: simple_byte = rword_q[7:0];
      endcase
    end
  end

  // next state logic
  always_comb begin
    state_d = state_q;
    open_d = open_q;
    len_d = len_q;
    flen_d = flen_q;
    sil_d = sil_q;
    cnt_d = cnt_q;
    crc_d = crc_q;
    rxcrc_d = rxcrc_q;
    hdr_d = hdr_q;
    rk_d = rk_q;
    rpos_d = rpos_q;
    rcrc_d = rcrc_q;
    raddr_d = raddr_q;
    rfunc_d = rfunc_q;
    rcode_d = rcode_q;
    rstart_d = rstart_q;
    rword_d = rword_q;
    mi_d = mi_q;
    mhi_d = mhi_q;
    mp_d = mp_q;
    res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rvld_d = rvld_q;
    item_pop_o = 1'b0;
    fs_we = 1'b0;
    fs_waddr = '0;
    fs_wdata = item_i.rx_byte;
    fs_raddr = '0;
    rf_we = 1'b0;
    rf_waddr = '0;
    rf_wdata = '0;
    rf_raddr = '0;
    len_eff = open_q ? len_q : '0;
    sil_n = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;
    tx_b = 8'h00;
    rv = rvld_q ? rf_rdata : 16'h0000;
    func = hdr_q[1];
    start = {hdr_q[2], hdr_q[3]};
    n = {hdr_q[4], hdr_q[5]};
    end_sum = {1'b0, start} + {1'b0, n};
    widx = {1'b0, rstart_q[7:0]} + {1'b0, mi_q};
    lo_b = (mp_q < 9'(flen_q)) ? fs_rdata : 8'h00;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          case (item_i.cmd)
            // received byte into the frame store
            mbrs_pkg::CMD_BYTE: begin
              sil_d = '0;
              if (len_eff == FL'(mbrs_pkg::FrameMax)) begin
                open_d = 1'b0;
                len_d = '0;
                res_d = mbrs_pkg::mk_drop(mbrs_pkg::DropOverflow);
                state_d = ST_EMIT;
              end else begin
                fs_we = 1'b1;
                fs_waddr = len_eff[FA-1:0];
                len_d = len_eff + 1'b1;
                open_d = 1'b1;
              end
            end
            // silence tick, may close the frame
            mbrs_pkg::CMD_TICK: begin
              if (open_q) begin
                sil_d = sil_n;
                if (sil_n > cfg_i.silence_ticks) begin
                  flen_d = len_q;
                  open_d = 1'b0;
                  len_d = '0;
                  sil_d = '0;
                  if (len_q < FL'(4)) begin
                    res_d = mbrs_pkg::mk_drop(mbrs_pkg::DropShort);
                    state_d = ST_EMIT;
                  end else begin
                    cnt_d = '0;
                    crc_d = mbrs_pkg::CrcInit;
                    for (int k = 0; k < 7; k++) begin
                      hdr_d[k] = 8'h00;
                    end
                    fs_raddr = '0;
                    state_d = ST_SWEEP;
                  end
                end
              end
            end
            // transmitter ready: next reply byte
            mbrs_pkg::CMD_TX: begin
              if (rk_q != mbrs_pkg::RplNone) begin
                if ({1'b0, rpos_q} < body_len) begin
                  if (rk_q == mbrs_pkg::RplRead && rpos_q >= 9'd3) begin
                    rf_raddr = RA'(rstart_q[7:0] + 8'(pm3 >> 1));
                    rvld_d = reg_vld_q[rf_raddr];
                    state_d = ST_TX_RD;
                  end else begin
                    rcrc_d = mbrs_pkg::crc_byte(rcrc_q, simple_byte);
                    rpos_d = rpos_q + 9'd1;
                    res_d = mbrs_pkg::mk_tx(simple_byte, 1'b0);
                    state_d = ST_EMIT;
                  end
                end else if ({1'b0, rpos_q} == body_len) begin
                  rpos_d = rpos_q + 9'd1;
                  res_d = mbrs_pkg::mk_tx(rcrc_q[7:0], 1'b0);
                  state_d = ST_EMIT;
                end else begin
                  res_d = mbrs_pkg::mk_tx(rcrc_q[15:8], 1'b1);
                  rk_d = mbrs_pkg::RplNone;
                  rpos_d = '0;
                  rcrc_d = mbrs_pkg::CrcInit;
                  state_d = ST_EMIT;
                end
              end
            end
            // local read
            mbrs_pkg::CMD_LRD: begin
              if (9'(item_i.index) < 9'(mbrs_pkg::RegCount)) begin
                rf_raddr = RA'(item_i.index);
                rvld_d = reg_vld_q[rf_raddr];
                state_d = ST_LRD;
              end else begin
                res_d = '0;
                res_d.kind = mbrs_pkg::KindRead;
                state_d = ST_EMIT;
              end
            end
            // local write
            mbrs_pkg::CMD_LWR: begin
              if (9'(item_i.index) < 9'(mbrs_pkg::RegCount)) begin
                rf_we = 1'b1;
                rf_waddr = RA'(item_i.index);
                rf_wdata = item_i.value;
              end
            end
            default: ;
          endcase
        end
      end

      ST_EMIT: begin
        if (ores_free) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_LRD: begin
        res_d = '0;
        res_d.kind = mbrs_pkg::KindRead;
        res_d.read_value = rv;
        state_d = ST_EMIT;
      end

      ST_TX_RD: begin
        tx_b = pm3[0] ? rv[7:0] : rv[15:8];
        rcrc_d = mbrs_pkg::crc_byte(rcrc_q, tx_b);
        rpos_d = rpos_q + 9'd1;
        res_d = mbrs_pkg::mk_tx(tx_b, 1'b0);
        state_d = ST_EMIT;
      end

      // walk the frame: header capture, crc, received crc
      ST_SWEEP: begin
        fs_raddr = FA'(cnt_q + 9'd1);
        cnt_d = cnt_q + 9'd1;
        if (cnt_q < 9'd7) begin
          hdr_d[cnt_q[2:0]] = fs_rdata;
        end
        if (cnt_q < 9'(flen_q) - 9'd2) begin
          crc_d = mbrs_pkg::crc_byte(crc_q, fs_rdata);
        end
        if (cnt_q == 9'(flen_q) - 9'd2) begin
          rxcrc_d[7:0] = fs_rdata;
        end
        if (cnt_q == 9'(flen_q) - 9'd1) begin
          rxcrc_d[15:8] = fs_rdata;
          state_d = ST_EVAL;
        end
      end

      // check address and crc, then serve the function
      ST_EVAL: begin
        state_d = ST_IDLE;
        if (hdr_q[0] != cfg_i.slave_address) begin
          res_d = mbrs_pkg::mk_drop(mbrs_pkg::DropAddr);
          state_d = ST_EMIT;
        end else if (rxcrc_q != crc_q) begin
          res_d = mbrs_pkg::mk_drop(mbrs_pkg::DropCrc);
          state_d = ST_EMIT;
        end else begin
          rpos_d = '0;
          rcrc_d = mbrs_pkg::CrcInit;
          raddr_d = hdr_q[0];
          rfunc_d = func;
          rk_d = mbrs_pkg::RplExc;
          rstart_d = '0;
          rword_d = '0;
          rcode_d = mbrs_pkg::ExcAddr;
          case (func)
            mbrs_pkg::FuncRead: begin
              if (start >= 16'(mbrs_pkg::RegCount) ||
                  end_sum > 17'(mbrs_pkg::RegCount) || n == 16'd0) begin
                rcode_d = mbrs_pkg::ExcAddr;
              end else begin
                rk_d = mbrs_pkg::RplRead;
                rstart_d = start;
                rword_d = n;
                rcode_d = 8'h00;
              end
            end
            mbrs_pkg::FuncWrite1: begin
              if ((start >= 16'(mbrs_pkg::ControlRegs) &&
                   start < 16'(mbrs_pkg::RegCount - mbrs_pkg::UpperWriteRegs)) ||
                  start >= 16'(mbrs_pkg::RegCount)) begin
                rcode_d = mbrs_pkg::ExcAddr;
              end else begin
                rf_we = 1'b1;
                rf_waddr = RA'(start);
                rf_wdata = n;
                rk_d = mbrs_pkg::RplWrite;
                rstart_d = start;
                rword_d = n;
                rcode_d = 8'h00;
                if (start < {8'h00, cfg_i.save_limit}) begin
                  res_d = '0;
                  res_d.kind = mbrs_pkg::KindSave;
                  res_d.save_index = start[7:0];
                  res_d.save_value = n;
                  state_d = ST_EMIT;
                end
              end
            end
            mbrs_pkg::FuncWriteN: begin
              if (start < 16'(mbrs_pkg::ControlRegs) ||
                  start >= 16'(mbrs_pkg::RegCount)) begin
                rcode_d = mbrs_pkg::ExcAddr;
              end else if (n == 16'd0 || n > 16'(mbrs_pkg::RegCount) ||
                           {9'h000, hdr_q[6]} != {n, 1'b0}) begin
                rcode_d = mbrs_pkg::ExcValue;
              end else begin
                rk_d = mbrs_pkg::RplWrite;
                rstart_d = start;
                rword_d = n;
                rcode_d = 8'h00;
                mi_d = '0;
                mp_d = 9'd7;
                state_d = ST_MW_A;
              end
            end
            default: begin
              rcode_d = mbrs_pkg::ExcFunc;
            end
          endcase
        end
      end

      // multiple write: high byte read
      ST_MW_A: begin
        fs_raddr = FA'(mp_q);
        state_d = ST_MW_B;
      end

      ST_MW_B: begin
        mhi_d = lo_b;
        fs_raddr = FA'(mp_q + 9'd1);
        mp_d = mp_q + 9'd1;
        state_d = ST_MW_C;
      end

      ST_MW_C: begin
        if (widx < 9'(mbrs_pkg::RegCount)) begin
          rf_we = 1'b1;
          rf_waddr = RA'(widx);
          rf_wdata = {mhi_q, lo_b};
        end
        mp_d = mp_q + 9'd1;
        mi_d = mi_q + 8'd1;
        if ({8'h00, mi_q} + 16'd1 == rword_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MW_A;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      open_q <= 1'b0;
      len_q <= '0;
      sil_q <= '0;
      rk_q <= mbrs_pkg::RplNone;
      rpos_q <= '0;
      rcrc_q <= mbrs_pkg::CrcInit;
      out_valid_q <= 1'b0;
      for (int k = 0; k < mbrs_pkg::RegCount; k++) begin
        reg_vld_q[k] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      open_q <= open_d;
      len_q <= len_d;
      sil_q <= sil_d;
      rk_q <= rk_d;
      rpos_q <= rpos_d;
      rcrc_q <= rcrc_d;
      out_valid_q <= out_valid_d;
      if (rf_we) begin
        reg_vld_q[rf_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    flen_q <= flen_d;
    cnt_q <= cnt_d;
    crc_q <= crc_d;
    rxcrc_q <= rxcrc_d;
    hdr_q <= hdr_d;
    raddr_q <= raddr_d;
    rfunc_q <= rfunc_d;
    rcode_q <= rcode_d;
    rstart_q <= rstart_d;
    rword_q <= rword_d;
    mi_q <= mi_d;
    mhi_q <= mhi_d;
    mp_q <= mp_d;
    res_q <= res_d;
    out_q <= out_d;
    rvld_q <= rvld_d;
  end

endmodule

### hw/rtl/modbus_rtu_slave_register_file_unit.sv
// modbus rtu slave with a 16-bit holding register file, top level
// depends on mbrs_pkg, mbrs_front, mbrs_back and mbrs_ram
//
// Each word carries one op: a received byte, a silence tick, a transmitter-ready
// request, or a local register read or write. The front queues up to four words;
// the back executes them one at a time. The tick that closes a frame walks the frame
// store through its single read port, one byte per cycle; a multiple-register write
// then writes its registers one at a time. Results leave through an output register,
// so the front keeps accepting while a result waits, until its queue is full.
// Register contents read as zero until written; there is no clearing pass after reset.
module modbus_rtu_slave_register_file_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     op_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic [7:0]                     local_index_i,
  input  logic [15:0]                    local_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     kind_o,
  output logic [7:0]                     tx_byte_o,
  output logic                           tx_last_o,
  output logic [7:0]                     save_index_o,
  output logic [15:0]                    save_value_o,
  output logic [15:0]                    read_value_o,
  output logic [1:0]                     drop_reason_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mbrs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);

  mbrs_pkg::cfg_t  cfg_q, cfg_d;
  mbrs_pkg::item_t item;
  mbrs_pkg::res_t  res;
  logic            item_valid, item_pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mbrs_pkg::CfgSlave:   cfg_d.slave_address = cfg_data_i[7:0];
        mbrs_pkg::CfgSilence: cfg_d.silence_ticks = cfg_data_i;
        mbrs_pkg::CfgSaveLim: cfg_d.save_limit = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address <= 8'd1;
      cfg_q.silence_ticks <= 16'd4;
      cfg_q.save_limit    <= 8'd32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mbrs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .rx_byte_i     (rx_byte_i),
    .local_index_i (local_index_i),
    .local_value_i (local_value_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  mbrs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (res)
  );

  assign kind_o        = res.kind;
  assign tx_byte_o     = res.tx_byte;
  assign tx_last_o     = res.tx_last;
  assign save_index_o  = res.save_index;
  assign save_value_o  = res.save_value;
  assign read_value_o  = res.read_value;
  assign drop_reason_o = res.drop_reason;

endmodule
